### sv/c8s_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8s_pkg
// Shared types and constants for the CHIP-8 subset core.
// ----------------------------------------------------------------------------
package c8s_pkg;

    localparam int MEM_AW   = 12;
    localparam int MEM_DEPTH = 4096;
    localparam int ROW_AW   = 5;
    localparam int ROWS     = 32;
    localparam int COLS     = 64;

    // Item operations.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_EXEC   = 2'd1;
    localparam logic [1:0] OP_ROW    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_HALTED  = 2'd2;

    // Opcode nibbles.
    localparam logic [3:0] OPC_CLS  = 4'h0;
    localparam logic [3:0] OPC_JP   = 4'h1;
    localparam logic [3:0] OPC_LD   = 4'h6;
    localparam logic [3:0] OPC_ADD  = 4'h7;
    localparam logic [3:0] OPC_LDI  = 4'hA;
    localparam logic [3:0] OPC_DRW  = 4'hD;

    localparam logic [3:0] REG_VF = 4'hF;

    // Shared unit operations.
    typedef enum logic {
        ALU_ADD,
        ALU_MASK
    } t_alu_op;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_ROW,
        S_F0,
        S_F1,
        S_F2,
        S_EXEC,
        S_ADD,
        S_D1,
        S_D2,
        S_DR0,
        S_DR1,
        S_RESP
    } t_state;

endpackage
`default_nettype wire

### sv/chip8_core_subset_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_core_subset_core
// CHIP-8 subset core: memory load, single-instruction execute, row readout.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ stream: op, address and data. Each item gives
// exactly one result item on the m_ stream: status, PC, fetched word, VF bit
// zero and one screen row. Items are handled one at a time under a small
// sequencer; the PC, ADD and sprite address sums and the sprite mask use
// one shared adder/mask unit. A sprite draw works one row at a time, each
// row passing S_DR0 and S_DR1, bounded by the one read port of the byte
// memory and the screen row read-modify-write. After reset the core sweeps
// the byte memory to zero, one byte a cycle, and only then raises s_tready.
// The screen and registers clear at once through valid bits.
// The result sits in an output register; a new item is accepted while it
// waits, but its own result is held back until the receiver has taken the
// earlier one.
// ----------------------------------------------------------------------------
module chip8_core_subset_core #(
    parameter int START_ADDRESS = 512
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // op[1:0], address[13:2], data[21:14], zeros[23:22]
    input  wire  [23:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // status[1:0], program_counter[13:2], instruction_word[29:14],
    // collision_flag[30], row_pixels[94:31], zero[95]
    output logic [95:0] m_tdata
);

    localparam logic [11:0] PC_START = START_ADDRESS[11:0];

    c8s_pkg::t_state r_state, n_state;

    logic [11:0] r_clr, n_clr;
    logic [1:0]  r_op, n_op;
    logic [11:0] r_addr, n_addr;
    logic [7:0]  r_data, n_data;
    logic [11:0] r_pc, n_pc;
    logic [11:0] r_idx, n_idx;
    logic        r_halt, n_halt;
    logic [15:0] r_word, n_word;
    logic [1:0]  r_status, n_status;
    logic [7:0]  r_vx, n_vx;
    logic [7:0]  r_vy, n_vy;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_hit, n_hit;
    logic        r_vf0, n_vf0;
    logic        r_out_vld;
    logic [94:0] r_out;

    // Memory port controls.
    logic        mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;

    // Register file: 16 entries, registered read, valid bits for reset.
    logic [7:0]  r_regs [16];
    logic [15:0] r_reg_vld;
    logic [7:0]  r_reg_q;
    logic        reg_we;
    logic [3:0]  reg_waddr, reg_raddr;
    logic [7:0]  reg_wdata, reg_rd;

    // Screen: 32 rows, registered read, valid bits for clear.
    logic [63:0] r_scr [c8s_pkg::ROWS];
    logic [31:0] r_row_vld;
    logic [63:0] r_scr_q;
    logic        r_scr_qv;
    logic        scr_we, scr_clr;
    logic [4:0]  scr_waddr, scr_raddr;
    logic [63:0] scr_wdata, row_rd;

    // Shared unit.
    c8s_pkg::t_alu_op alu_op;
    logic [11:0] alu_a, alu_b, alu_sum;
    logic [63:0] alu_mask;

    logic        accept, out_free;

    c8s_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    c8s_alu u_alu (
        .i_op   (alu_op),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_sum  (alu_sum),
        .o_mask (alu_mask)
    );

    assign reg_rd   = r_reg_q;
    assign row_rd   = r_scr_qv ? r_scr_q : 64'd0;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !r_out_vld || m_tready;
    assign m_tvalid = r_out_vld;
    assign m_tdata  = {1'b0, r_out};

    // Register file storage.
    always_ff @(posedge i_clk) begin
        if (reg_we) begin
            r_regs[reg_waddr] <= reg_wdata;
        end
        r_reg_q <= r_reg_vld[reg_raddr] ? r_regs[reg_raddr] : 8'd0;
    end

    // Screen storage.
    always_ff @(posedge i_clk) begin
        if (scr_we) begin
            r_scr[scr_waddr] <= scr_wdata;
        end
        r_scr_q <= r_scr[scr_raddr];
    end

    // State, control registers and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= c8s_pkg::S_CLEAR;
            r_clr     <= '0;
            r_pc      <= PC_START;
            r_idx     <= '0;
            r_halt    <= 1'b0;
            r_vf0     <= 1'b0;
            r_out_vld <= 1'b0;
            r_reg_vld <= '0;
            r_row_vld <= '0;
            r_scr_qv  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pc     <= n_pc;
            r_idx    <= n_idx;
            r_halt   <= n_halt;
            r_vf0    <= n_vf0;
            r_scr_qv <= r_row_vld[scr_raddr];
            if (reg_we) begin
                r_reg_vld[reg_waddr] <= 1'b1;
            end
            if (scr_clr) begin
                r_row_vld <= '0;
            end else if (scr_we) begin
                r_row_vld[scr_waddr] <= 1'b1;
            end
            if (r_state == c8s_pkg::S_RESP && out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Item payload and working registers.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_data   <= n_data;
        r_word   <= n_word;
        r_status <= n_status;
        r_vx     <= n_vx;
        r_vy     <= n_vy;
        r_cnt    <= n_cnt;
        r_hit    <= n_hit;
        if (r_state == c8s_pkg::S_RESP && out_free) begin
            r_out <= {(r_op == c8s_pkg::OP_ROW && r_status == c8s_pkg::ST_DONE)
                      ? row_rd : 64'd0,
                      r_vf0, r_word, r_pc, r_status};
        end
    end

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_op     = r_op;
        n_addr   = r_addr;
        n_data   = r_data;
        n_pc     = r_pc;
        n_idx    = r_idx;
        n_halt   = r_halt;
        n_word   = r_word;
        n_status = r_status;
        n_vx     = r_vx;
        n_vy     = r_vy;
        n_cnt    = r_cnt;
        n_hit    = r_hit;
        n_vf0    = r_vf0;
        s_tready = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_data;
        mem_raddr = r_pc;
        reg_we    = 1'b0;
        reg_waddr = r_word[11:8];
        reg_wdata = r_word[7:0];
        reg_raddr = r_word[11:8];
        scr_we    = 1'b0;
        scr_clr   = 1'b0;
        scr_waddr = r_vy[4:0] + {1'b0, r_cnt};
        scr_wdata = row_rd ^ alu_mask;
        scr_raddr = r_addr[4:0];
        alu_op    = c8s_pkg::ALU_ADD;
        alu_a     = r_pc;
        alu_b     = 12'd1;

        case (r_state)
            // Sweep the byte memory to zero after reset.
            c8s_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = 8'd0;
                n_clr     = r_clr + 12'd1;
                if (r_clr == 12'hFFF) begin
                    n_state = c8s_pkg::S_IDLE;
                end
            end
            // Take an item and dispatch on its operation.
            c8s_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    n_op     = s_tdata[1:0];
                    n_addr   = s_tdata[13:2];
                    n_data   = s_tdata[21:14];
                    n_word   = '0;
                    n_status = c8s_pkg::ST_DONE;
                    if (r_halt) begin
                        n_status = c8s_pkg::ST_HALTED;
                        n_state  = c8s_pkg::S_RESP;
                    end else begin
                        case (s_tdata[1:0])
                            c8s_pkg::OP_LOAD: n_state = c8s_pkg::S_LOAD;
                            c8s_pkg::OP_EXEC: n_state = c8s_pkg::S_F0;
                            c8s_pkg::OP_ROW:  n_state = c8s_pkg::S_ROW;
                            default:          n_state = c8s_pkg::S_RESP;
                        endcase
                    end
                end
            end
            c8s_pkg::S_LOAD: begin
                mem_we  = 1'b1;
                n_state = c8s_pkg::S_RESP;
            end
            // Row read: the registered screen read lands in S_RESP.
            c8s_pkg::S_ROW: begin
                n_state = c8s_pkg::S_RESP;
            end
            // Fetch the high byte, then the low byte at PC plus one.
            c8s_pkg::S_F0: begin
                mem_raddr = r_pc;
                n_state   = c8s_pkg::S_F1;
            end
            c8s_pkg::S_F1: begin
                mem_raddr     = alu_sum;
                n_word[15:8]  = mem_rdata;
                n_state       = c8s_pkg::S_F2;
            end
            c8s_pkg::S_F2: begin
                alu_b        = 12'd2;
                n_pc         = alu_sum;
                n_word[7:0]  = mem_rdata;
                n_state      = c8s_pkg::S_EXEC;
            end
            // Decode and execute.
            c8s_pkg::S_EXEC: begin
                n_state = c8s_pkg::S_RESP;
                case (r_word[15:12])
                    c8s_pkg::OPC_CLS: scr_clr = 1'b1;
                    c8s_pkg::OPC_JP:  n_pc = r_word[11:0];
                    c8s_pkg::OPC_LD: begin
                        reg_we = 1'b1;
                        if (r_word[11:8] == c8s_pkg::REG_VF) begin
                            n_vf0 = r_word[0];
                        end
                    end
                    c8s_pkg::OPC_ADD: n_state = c8s_pkg::S_ADD;
                    c8s_pkg::OPC_LDI: n_idx = r_word[11:0];
                    c8s_pkg::OPC_DRW: begin
                        reg_raddr = r_word[11:8];
                        n_state   = c8s_pkg::S_D1;
                    end
                    default: begin
                        n_halt   = 1'b1;
                        n_status = c8s_pkg::ST_UNKNOWN;
                    end
                endcase
            end
            // VX plus NN with 8-bit wrap.
            c8s_pkg::S_ADD: begin
                alu_a     = {4'd0, reg_rd};
                alu_b     = {4'd0, r_word[7:0]};
                reg_we    = 1'b1;
                reg_wdata = alu_sum[7:0];
                if (r_word[11:8] == c8s_pkg::REG_VF) begin
                    n_vf0 = alu_sum[0];
                end
                n_state = c8s_pkg::S_RESP;
            end
            // Draw: fetch VX and VY before VF is touched.
            c8s_pkg::S_D1: begin
                n_vx      = reg_rd;
                reg_raddr = r_word[7:4];
                n_state   = c8s_pkg::S_D2;
            end
            c8s_pkg::S_D2: begin
                n_vy  = reg_rd;
                n_cnt = '0;
                n_hit = 1'b0;
                if (r_word[3:0] == 4'd0) begin
                    reg_we    = 1'b1;
                    reg_waddr = c8s_pkg::REG_VF;
                    reg_wdata = 8'd0;
                    n_vf0     = 1'b0;
                    n_state   = c8s_pkg::S_RESP;
                end else begin
                    n_state = c8s_pkg::S_DR0;
                end
            end
            // Per sprite row: read byte at I plus row and the screen row.
            c8s_pkg::S_DR0: begin
                alu_a     = r_idx;
                alu_b     = {8'd0, r_cnt};
                mem_raddr = alu_sum;
                scr_raddr = r_vy[4:0] + {1'b0, r_cnt};
                n_state   = c8s_pkg::S_DR1;
            end
            // XOR the placed sprite into the row and note any collision.
            c8s_pkg::S_DR1: begin
                alu_op = c8s_pkg::ALU_MASK;
                alu_a  = {4'd0, mem_rdata};
                alu_b  = {4'd0, r_vx};
                scr_we = 1'b1;
                n_hit  = r_hit || ((row_rd & alu_mask) != 64'd0);
                n_cnt  = r_cnt + 4'd1;
                if (r_cnt == r_word[3:0] - 4'd1) begin
                    reg_we    = 1'b1;
                    reg_waddr = c8s_pkg::REG_VF;
                    reg_wdata = {7'd0, n_hit};
                    n_vf0     = n_hit;
                    n_state   = c8s_pkg::S_RESP;
                end else begin
                    n_state = c8s_pkg::S_DR0;
                end
            end
            // Hand the result to the output register once it is free.
            c8s_pkg::S_RESP: begin
                scr_raddr = r_addr[4:0];
                if (out_free) begin
                    n_state = c8s_pkg::S_IDLE;
                end
            end
            default: n_state = c8s_pkg::S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### sv/c8s_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8s_ram
// Byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module c8s_ram (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire [c8s_pkg::MEM_AW-1:0]    i_waddr,
    input  wire [7:0]                    i_wdata,
    input  wire [c8s_pkg::MEM_AW-1:0]    i_raddr,
    output logic [7:0]                   o_rdata
);

    logic [7:0] r_mem [c8s_pkg::MEM_DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### sv/c8s_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8s_alu
// Shared unit: a 12-bit adder, or a sprite byte placed on a 64-pixel row
// at a wrapping column offset.
// ----------------------------------------------------------------------------
module c8s_alu (
    input  c8s_pkg::t_alu_op              i_op,
    input  wire [11:0]                    i_a,
    input  wire [11:0]                    i_b,
    output logic [11:0]                   o_sum,
    output logic [c8s_pkg::COLS-1:0]      o_mask
);

    logic [7:0]   rev;
    logic [127:0] dbl;
    logic [127:0] shl;

    always_comb begin
        // Sprite bit 7 lands on the leftmost column, so reverse the byte.
        for (int j = 0; j < 8; j++) begin
            rev[j] = i_a[7-j];
        end
        dbl   = {56'd0, rev, 56'd0, rev};
        shl   = dbl << i_b[5:0];
        o_sum = '0;
        o_mask = '0;
        case (i_op)
            c8s_pkg::ALU_ADD:  o_sum  = i_a + i_b;
            c8s_pkg::ALU_MASK: o_mask = shl[127:64];
            default:           o_sum  = '0;
        endcase
    end

endmodule
`default_nettype wire

### tb/sv/chip8_core_subset_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_core_subset_checker
// Watches both item streams of the CHIP-8 subset core, keeps its own copy of
// the core state, works out the result of every accepted input item and
// compares it field by field with the result items that come out.
// ----------------------------------------------------------------------------
module chip8_core_subset_checker #(
    parameter int START_ADDRESS = 512
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [23:0] i_s_tdata,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [95:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [63:0] pixels;
        logic        vf_bit;
        logic [15:0] word;
        logic [11:0] pc;
        logic [1:0]  status;
    } t_result;

    logic [7:0]  mem_copy [c8s_pkg::MEM_DEPTH];
    logic [63:0] screen_copy [c8s_pkg::ROWS];
    logic [7:0]  vreg [16];
    logic [11:0] index_copy;
    logic [11:0] pc_copy;
    logic        halted_copy;
    t_result     expected_results [$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch in %s: got %h, expected %h", what, got, want);
        o_fail_count++;
    endtask

    // Sprite draw: XOR each sprite row into the screen with wrap at the edges.
    function automatic void draw_sprite(input logic [3:0] xr, input logic [3:0] yr,
                                        input logic [3:0] rows);
        logic [5:0]  vx;
        logic [4:0]  vy;
        logic [63:0] mask;
        logic [7:0]  sprite;
        logic        hit;
        vx  = vreg[xr][5:0];
        vy  = vreg[yr][4:0];
        hit = 1'b0;
        for (int i = 0; i < rows; i++) begin
            sprite = mem_copy[12'(index_copy + i)];
            mask   = '0;
            for (int j = 0; j < 8; j++) begin
                if (sprite[7 - j]) mask[6'(vx + j)] = 1'b1;
            end
            if ((screen_copy[5'(vy + i)] & mask) != 0) hit = 1'b1;
            screen_copy[5'(vy + i)] ^= mask;
        end
        vreg[c8s_pkg::REG_VF] = {7'd0, hit};
    endfunction

    // Work out the result of one input item and update the state copy.
    function automatic t_result core_step(input logic [23:0] item);
        t_result     r;
        logic [1:0]  op;
        logic [11:0] addr;
        logic [15:0] w;
        op   = item[1:0];
        addr = item[13:2];
        r    = '0;
        if (halted_copy) begin
            r.status = c8s_pkg::ST_HALTED;
        end else if (op == c8s_pkg::OP_LOAD) begin
            mem_copy[addr] = item[21:14];
        end else if (op == c8s_pkg::OP_EXEC) begin
            w       = {mem_copy[pc_copy], mem_copy[12'(pc_copy + 1)]};
            r.word  = w;
            pc_copy = 12'(pc_copy + 2);
            case (w[15:12])
                c8s_pkg::OPC_CLS:
                    for (int k = 0; k < c8s_pkg::ROWS; k++) screen_copy[k] = '0;
                c8s_pkg::OPC_JP:  pc_copy = w[11:0];
                c8s_pkg::OPC_LD:  vreg[w[11:8]] = w[7:0];
                c8s_pkg::OPC_ADD: vreg[w[11:8]] = 8'(vreg[w[11:8]] + w[7:0]);
                c8s_pkg::OPC_LDI: index_copy = w[11:0];
                c8s_pkg::OPC_DRW: draw_sprite(w[11:8], w[7:4], w[3:0]);
                default: begin
                    halted_copy = 1'b1;
                    r.status    = c8s_pkg::ST_UNKNOWN;
                end
            endcase
        end else if (op == c8s_pkg::OP_ROW) begin
            r.pixels = screen_copy[addr[4:0]];
        end
        r.pc     = pc_copy;
        r.vf_bit = vreg[c8s_pkg::REG_VF][0];
        return r;
    endfunction

    // Predict on input items, compare on result items.
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            for (int k = 0; k < c8s_pkg::MEM_DEPTH; k++) mem_copy[k] = '0;
            for (int k = 0; k < c8s_pkg::ROWS; k++) screen_copy[k] = '0;
            for (int k = 0; k < 16; k++) vreg[k] = '0;
            index_copy   = '0;
            pc_copy      = 12'(START_ADDRESS);
            halted_copy  = 1'b0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) expected_results.push_back(core_step(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[94:0];
                if (i_m_tdata[95]) report_mismatch("padding", 64'd1, 64'd0);
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'(got.pc), 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.pc != want.pc)
                        report_mismatch("pc", 64'(got.pc), 64'(want.pc));
                    if (got.word != want.word)
                        report_mismatch("instruction", 64'(got.word), 64'(want.word));
                    if (got.vf_bit != want.vf_bit)
                        report_mismatch("collision", 64'(got.vf_bit), 64'(want.vf_bit));
                    if (got.pixels != want.pixels)
                        report_mismatch("row pixels", got.pixels, want.pixels);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule
`default_nettype wire

### tb/sv/chip8_core_subset_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_core_subset_core_tb
// Drives load, execute, row read and unused items into the CHIP-8 subset
// core with random gaps and output stalls; the checker predicts and compares
// results. Programs are loaded, run and read back; a halt ends the stimulus.
// ----------------------------------------------------------------------------
module chip8_core_subset_core_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    logic        calm = 1'b0;
    logic [11:0] load_ptr;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    chip8_core_subset_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    chip8_core_subset_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver stalls in about 16 percent of cycles, except in calm stretches.
    always @(posedge i_clk) m_tready <= calm || ($urandom_range(99) >= 16);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Send one item, with an occasional idle gap first.
    task automatic send_item(input logic [1:0] op, input logic [11:0] addr,
                             input logic [7:0] data);
        while (!calm && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, data, addr, op};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic load_word(input logic [11:0] addr, input logic [15:0] w);
        send_item(c8s_pkg::OP_LOAD, addr, w[15:8]);
        send_item(c8s_pkg::OP_LOAD, 12'(addr + 1), w[7:0]);
    endtask

    // A valid random instruction, weighted towards draws.
    function automatic logic [15:0] random_instruction();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(9))
            0:       return {c8s_pkg::OPC_CLS, r[11:0]};
            1:       return {c8s_pkg::OPC_LD, r[11:0]};
            2, 3:    return {c8s_pkg::OPC_ADD, r[11:0]};
            4:       return {c8s_pkg::OPC_LDI, r[11:0]};
            default: return {c8s_pkg::OPC_DRW, r[11:0]};
        endcase
    endfunction

    initial begin
        logic [15:0] w;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fetch wrap, sprite memory wrap, draw at edges with VF.
        load_word(12'h200, {c8s_pkg::OPC_JP, 12'hFFF});
        send_item(c8s_pkg::OP_LOAD, 12'hFFF, {c8s_pkg::OPC_LD, 4'hF});
        send_item(c8s_pkg::OP_LOAD, 12'h000, 8'h3F);
        load_word(12'h001, {c8s_pkg::OPC_LD, 4'h0, 8'hFF});
        load_word(12'h003, {c8s_pkg::OPC_LDI, 12'hFFF});
        send_item(c8s_pkg::OP_LOAD, 12'h005, {c8s_pkg::OPC_DRW, 4'hF});
        send_item(c8s_pkg::OP_LOAD, 12'h006, 8'hFF);
        load_word(12'h007, {c8s_pkg::OPC_DRW, 4'h0, 4'hF, 4'h2});
        load_word(12'h009, {c8s_pkg::OPC_ADD, 4'h0, 8'hFF});
        repeat (2) send_item(c8s_pkg::OP_EXEC, 12'h000, 8'h00);
        // The wrapped fetch is done, so the last byte now serves as sprite data.
        send_item(c8s_pkg::OP_LOAD, 12'hFFF, 8'hFF);
        repeat (4) send_item(c8s_pkg::OP_EXEC, 12'h000, 8'h00);
        send_item(c8s_pkg::OP_ROW, 12'hFFF, 8'hFF);
        send_item(c8s_pkg::OP_ROW, 12'h03F, 8'h00);
        send_item(c8s_pkg::OP_ROW, 12'h000, 8'h00);
        load_word(12'h00B, {c8s_pkg::OPC_CLS, 12'hFFF});
        send_item(c8s_pkg::OP_EXEC, 12'h000, 8'h00);
        send_item(c8s_pkg::OP_UNUSED, 12'hABC, 8'h55);

        // Hold off until every result is in, then a calm stretch.
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        calm <= 1'b1;

        // Random programs: load instructions then run them, reading rows.
        load_ptr = 12'h00D;
        for (int prog = 0; prog < 24; prog++) begin
            if (prog == 4) calm <= 1'b0;
            for (int k = 0; k < 10; k++) begin
                w = random_instruction();
                load_word(12'(load_ptr + 2 * k), w);
            end
            load_word(12'(load_ptr + 20), {c8s_pkg::OPC_JP, 12'(load_ptr + 22)});
            if ($urandom_range(3) == 0)
                send_item(c8s_pkg::OP_LOAD, 12'($urandom), 8'($urandom));
            for (int k = 0; k < 11; k++) begin
                send_item(c8s_pkg::OP_EXEC, 12'($urandom), 8'($urandom));
                if ($urandom_range(2) == 0)
                    send_item(c8s_pkg::OP_ROW, 12'($urandom), 8'($urandom));
            end
            load_ptr = 12'(load_ptr + 22);
        end
        for (int k = 0; k < 32; k++) send_item(c8s_pkg::OP_ROW, 12'(k), 8'h00);

        // Unknown opcode halts, then every operation is refused.
        load_word(load_ptr, 16'hF123);
        repeat (2) send_item(c8s_pkg::OP_EXEC, 12'h000, 8'h00);
        for (int k = 0; k < 12; k++)
            send_item(2'($urandom_range(3)), 12'($urandom), 8'($urandom));
        s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
sv/c8s_pkg.sv
sv/c8s_ram.sv
sv/c8s_alu.sv
sv/chip8_core_subset_core.sv
tb/sv/chip8_core_subset_checker.sv
tb/sv/chip8_core_subset_core_tb.sv
